// ----- rtl/core/fbm_pkg.sv -----
`default_nettype none

package fbm_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int MAX_OCTAVES_DEF = 8;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [23:0] INV_SCALE_RST  = 24'd8192;
  localparam logic [16:0] THRESHOLD_RST  = 17'd0;
  localparam logic [16:0] BLEND_RST      = 17'd32768;
  localparam logic [3:0]  OCTAVES_RST    = 4'd3;
  localparam logic [31:0] SEED_RST       = 32'd0;

  localparam logic [16:0] Q16_ONE        = 17'd65536;
  localparam logic [16:0] Q16_HALF       = 17'd32768;

  localparam logic [31:0] HASH_MUL_Y     = 32'd57;
  localparam logic [31:0] HASH_MUL_SEED  = 32'd131;
  localparam logic [31:0] HASH_MUL_SQ    = 32'd15731;
  localparam logic [31:0] HASH_ADD_SQ    = 32'd789221;
  localparam logic [31:0] HASH_ADD_OUT   = 32'd1376312589;
  localparam logic [31:0] HASH_MASK      = 32'h7fffffff;
  localparam logic [31:0] NOISE_BIAS     = 32'h40000000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_INV_SCALE = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_BLEND     = 3'd2,
    REG_OCTAVES   = 3'd3,
    REG_SEED      = 3'd4
  } fbm_reg_e;

  // settings the back end of the pipeline needs
  typedef struct packed {
    logic [16:0] threshold;
    logic [16:0] blend;
    logic [3:0]  octaves;
  } fbm_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/fbm_hash_lane.sv -----
`default_nettype none

module fbm_hash_lane import fbm_pkg::*; #(
  parameter int PX_W        = COORD_BITS_DEF + 24,
  parameter int OCT         = 0,
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic [4:0]                    en_i,
  input  wire logic [PX_W-1:0]               px_i,
  input  wire logic [PX_W-1:0]               py_i,
  input  wire logic [31:0]                   seed_i,
  input  wire logic [3:0]                    octaves_i,
  output logic signed [MAX_OCTAVES+30:0]     w_o
);

  localparam int WW = MAX_OCTAVES + 31;

  logic [63:0] ext_x, ext_y;
  logic [31:0] cx, cy, n0, n1;
  logic [31:0] n2_q, n3_q, n4_q;
  logic [31:0] sq_d, sq_q, t_d, t_q, p_d, p_q;
  logic [31:0] h;
  logic signed [31:0] v;
  logic        active;
  logic [3:0]  sh;
  logic signed [WW-1:0] w_d, w_q;

  // cell coordinate: bits [47:16] of the scaled position times 2^OCT
  assign ext_x = 64'(px_i) << OCT;
  assign ext_y = 64'(py_i) << OCT;
  assign cx    = ext_x[47:16];
  assign cy    = ext_y[47:16];
  assign n0    = cx + cy * HASH_MUL_Y + seed_i * HASH_MUL_SEED;
  assign n1    = (n0 << 13) ^ n0;

  assign sq_d  = n2_q * n2_q;
  assign t_d   = sq_q * HASH_MUL_SQ + HASH_ADD_SQ;
  assign p_d   = n4_q * t_q;

  assign h      = (p_q + HASH_ADD_OUT) & HASH_MASK;
  assign v      = signed'(NOISE_BIAS - h);
  assign active = (4'(OCT) < octaves_i);
  assign sh     = octaves_i - 4'(OCT) - 4'd1;
  assign w_d    = active ? (WW'(v) <<< sh) : '0;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      n2_q <= n1;
    end
    if (en_i[1]) begin
      sq_q <= sq_d;
      n3_q <= n2_q;
    end
    if (en_i[2]) begin
      t_q  <= t_d;
      n4_q <= n3_q;
    end
    if (en_i[4]) begin
      w_q  <= w_d;
    end
  end

  // n travels beside t so the final product pairs values of the same request
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      p_q <= p_d;
    end
  end

  assign w_o = w_q;

endmodule

`default_nettype wire

// ----- rtl/core/fbm_sum_tree.sv -----
`default_nettype none

module fbm_sum_tree import fbm_pkg::*; #(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic [1:0]                  en_i,
  input  wire logic signed [MAX_OCTAVES+30:0] w_i [MAX_OCTAVES],
  output logic signed [MAX_OCTAVES+34:0]   sum_o
);

  localparam int SW = MAX_OCTAVES + 35;
  localparam int NG = (MAX_OCTAVES + 3) / 4;

  logic signed [SW-1:0] grp_d [NG];
  logic signed [SW-1:0] grp_q [NG];
  logic signed [SW-1:0] sum_d, sum_q;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < 4; j++) begin
        if (g * 4 + j < MAX_OCTAVES) begin
          grp_d[g] = grp_d[g] + SW'(w_i[g * 4 + j]);
        end
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int g = 0; g < NG; g++) begin
      sum_d = sum_d + grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      grp_q <= grp_d;
    end
    if (en_i[1]) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ----- rtl/core/fbm_darken.sv -----
`default_nettype none

module fbm_darken import fbm_pkg::*; #(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic [1:0]                     en_i,
  input  wire logic signed [MAX_OCTAVES+34:0] sum_i,
  input  wire logic [2:0][7:0]                chan_i,
  input  wire fbm_cfg_t                       cfg_i,
  output logic [2:0][7:0]                     out_o,
  output logic                                mask_o
);

  localparam int SW = MAX_OCTAVES + 35;
  localparam int LW = MAX_OCTAVES + 31;
  localparam int CW = (SW > LW) ? SW : LW;

  logic [SW-1:0]    mag;
  logic [LW-1:0]    limit;
  logic             crack_d, crack_q;
  logic [2:0][7:0]  chan_q;
  logic [16:0]      blend_sat, keep;
  logic [24:0]      prod [3];
  logic [2:0][7:0]  out_d, out_q;
  logic             mask_q;

  // |S| > thr * 2^14 * (2^K - 1)
  assign mag     = sum_i[SW-1] ? SW'(-sum_i) : SW'(sum_i);
  assign limit   = (LW'(cfg_i.threshold) << (5'd14 + 5'(cfg_i.octaves)))
                 - (LW'(cfg_i.threshold) << 14);
  assign crack_d = CW'(mag) > CW'(limit);

  assign blend_sat = (cfg_i.blend > Q16_ONE) ? Q16_HALF : cfg_i.blend;
  assign keep      = Q16_ONE - blend_sat;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c]  = 25'(chan_q[c]) * 25'(keep);
      out_d[c] = crack_q ? prod[c][23:16] : chan_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      crack_q <= crack_d;
      chan_q  <= chan_i;
    end
    if (en_i[1]) begin
      out_q  <= out_d;
      mask_q <= crack_q;
    end
  end

  assign out_o  = out_q;
  assign mask_o = mask_q;

endmodule

`default_nettype wire

// ----- rtl/core/fbm_noise_threshold_darken.sv -----
`default_nettype none

// Channel  Direction  Handshake               Payload
// in       sink       in_valid_i / in_stall_o  x_pos_i y_pos_i chan_zero_i chan_one_i chan_two_i
// out      source     out_valid_o / out_stall_i out_zero_o out_one_o out_two_o crack_mask_o
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i cfg_data_i
//
// Eleven register stages; one pixel per cycle while out_stall_i is low.
// Latency is set by the hash lanes: three dependent 32-bit multiplies per octave,
// one octave per parallel lane, then a two-level adder tree and the compare.
// Each stage advances on its own, so bubbles are squeezed out under a stall.
// Reset clears the valid bits and loads the register defaults.

module fbm_noise_threshold_darken import fbm_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [COORD_BITS-1:0]  x_pos_i,
  input  wire logic [COORD_BITS-1:0]  y_pos_i,
  input  wire logic [7:0]             chan_zero_i,
  input  wire logic [7:0]             chan_one_i,
  input  wire logic [7:0]             chan_two_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [7:0]                  out_zero_o,
  output logic [7:0]                  out_one_o,
  output logic [7:0]                  out_two_o,
  output logic                        crack_mask_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int NS   = 11;
  localparam int PX_W = COORD_BITS + 24;
  localparam int WW   = MAX_OCTAVES + 31;
  localparam int SW   = MAX_OCTAVES + 35;
  localparam int CH_STAGES = 9;

  logic [23:0] inv_scale_q;
  logic [16:0] threshold_q;
  logic [16:0] blend_q;
  logic [3:0]  octaves_q;
  logic [31:0] seed_q;
  logic [3:0]  k_eff;
  fbm_cfg_t    cfg;

  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   en_w;

  logic [COORD_BITS-1:0] x0_q, y0_q;
  logic [PX_W-1:0]       px_q, py_q;
  logic [2:0][7:0]       chan_q [CH_STAGES];
  logic signed [WW-1:0]  w_lane [MAX_OCTAVES];
  logic signed [SW-1:0]  sum_w;
  logic [2:0][7:0]       out_w;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_scale_q <= INV_SCALE_RST;
      threshold_q <= THRESHOLD_RST;
      blend_q     <= BLEND_RST;
      octaves_q   <= OCTAVES_RST;
      seed_q      <= SEED_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_INV_SCALE: inv_scale_q <= cfg_data_i[23:0];
        REG_THRESHOLD: threshold_q <= cfg_data_i[16:0];
        REG_BLEND:     blend_q     <= cfg_data_i[16:0];
        REG_OCTAVES:   octaves_q   <= cfg_data_i[3:0];
        REG_SEED:      seed_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (octaves_q == 4'd0) begin
      k_eff = 4'd1;
    end else if (32'(octaves_q) > 32'(MAX_OCTAVES)) begin
      k_eff = 4'(MAX_OCTAVES);
    end else begin
      k_eff = octaves_q;
    end
  end

  assign cfg.threshold = threshold_q;
  assign cfg.blend     = blend_q;
  assign cfg.octaves   = k_eff;

  // per-stage advance: a stage loads when empty or when the next one loads
  always_comb begin
    en_w[NS] = !out_stall_i;
    for (int s = NS - 1; s >= 0; s--) begin
      en_w[s] = !v_q[s] || en_w[s+1];
    end
  end

  assign v_d        = {v_q[NS-2:0], in_valid_i};
  assign in_stall_o = !en_w[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (en_w[s]) begin
          v_q[s] <= v_d[s];
        end
      end
    end
  end

  // stages 0 and 1: capture, then scale coordinates
  always_ff @(posedge clk_i) begin
    if (en_w[0]) begin
      x0_q      <= x_pos_i;
      y0_q      <= y_pos_i;
      chan_q[0] <= {chan_two_i, chan_one_i, chan_zero_i};
    end
    if (en_w[1]) begin
      px_q <= PX_W'(x0_q) * PX_W'(inv_scale_q);
      py_q <= PX_W'(y0_q) * PX_W'(inv_scale_q);
    end
    for (int s = 1; s < CH_STAGES; s++) begin
      if (en_w[s]) begin
        chan_q[s] <= chan_q[s-1];
      end
    end
  end

  // stages 2 to 6: one hash lane per octave
  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
    fbm_hash_lane #(
      .PX_W        (PX_W),
      .OCT         (i),
      .MAX_OCTAVES (MAX_OCTAVES)
    ) u_lane (
      .clk_i     (clk_i),
      .en_i      (en_w[6:2]),
      .px_i      (px_q),
      .py_i      (py_q),
      .seed_i    (seed_q),
      .octaves_i (k_eff),
      .w_o       (w_lane[i])
    );
  end

  // stages 7 and 8
  fbm_sum_tree #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_sum (
    .clk_i (clk_i),
    .en_i  (en_w[8:7]),
    .w_i   (w_lane),
    .sum_o (sum_w)
  );

  // stages 9 and 10
  fbm_darken #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_darken (
    .clk_i  (clk_i),
    .en_i   (en_w[10:9]),
    .sum_i  (sum_w),
    .chan_i (chan_q[CH_STAGES-1]),
    .cfg_i  (cfg),
    .out_o  (out_w),
    .mask_o (crack_mask_o)
  );

  assign out_valid_o = v_q[NS-1];
  assign out_zero_o  = out_w[0];
  assign out_one_o   = out_w[1];
  assign out_two_o   = out_w[2];

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v_q[0])
    else $error("accepted request did not enter stage 0");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && v_q[0]))
    else $error("input stalled with room in the pipeline");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_w) && $stable(crack_mask_o))
    else $error("stalled result left the output stage");

endmodule

`default_nettype wire
